/* rtl/deq_pkg.sv */
// Shared constants, payload types and controller/datapath interface types for the deque.
package deq_pkg;

  // Storage geometry.
  localparam int CAPACITY  = 64;
  localparam int WORD_BITS = 32;
  localparam int IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);

  typedef logic [IDX_BITS-1:0]         idx_t;
  typedef logic [CNT_BITS-1:0]         cnt_t;
  typedef logic signed [WORD_BITS-1:0] word_t;

  // Operation codes carried in the kind field.
  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_DUMP       = 3'd4
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Input word.
  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] word_in;
  } in_t;

  // Result word.
  typedef struct packed {
    logic signed [31:0] word_out;
    logic [1:0]         status;
    logic               last_of_run;
  } out_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the accepted operation
    logic exec_imm;    // finish a push or an error case with a one-shot result
    logic start_read;  // issue the first store read of a pop or a dump
    logic emit_read;   // move read data to the output, fetch the next dump entry
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_kind_ok;  // incoming kind is a defined operation
    logic imm_case;    // latched operation finishes without a store read
    logic read_last;   // the pending read result is the final one
    logic out_free;    // output register can take a word this cycle
  } dp_stat_t;

endpackage

/* rtl/deq_dp.sv */
// Datapath of the deque: ring store, front and occupancy registers, dump walker, output register.
module deq_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  deq_pkg::in_t      in_data,
  input  deq_pkg::dp_cmd_t  cmd,
  output deq_pkg::dp_stat_t stat,
  output logic              out_valid,
  input  logic              out_stall,
  output deq_pkg::out_t     out_data
);
  import deq_pkg::*;

  // Ring index helpers; ring_add wraps the sum at most once, so it is exact only for an offset up to the capacity.
  function automatic idx_t ring_add(idx_t base, cnt_t off);
    logic [CNT_BITS:0] s;
    s = (CNT_BITS+1)'(base) + (CNT_BITS+1)'(off);
    if (s >= (CNT_BITS+1)'(CAPACITY)) begin
      s = s - (CNT_BITS+1)'(CAPACITY);
    end
    return s[IDX_BITS-1:0];
  endfunction

  function automatic idx_t ring_inc(idx_t i);
    return (i == IDX_BITS'(CAPACITY - 1)) ? '0 : i + IDX_BITS'(1);
  endfunction

  function automatic idx_t ring_dec(idx_t i);
    return (i == '0) ? IDX_BITS'(CAPACITY - 1) : i - IDX_BITS'(1);
  endfunction

  word_t              mem [CAPACITY];
  word_t              rd_data_r;
  logic [2:0]         op_kind_r;
  word_t              op_word_r;
  idx_t               front_r, front_nxt;
  cnt_t               occ_r, occ_nxt;
  idx_t               dptr_r, dptr_nxt;
  cnt_t               remain_r, remain_nxt;
  out_t               out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               op_push, op_pop, is_empty, is_full;
  logic               mem_we, mem_re;
  idx_t               wr_addr, rd_addr, back_idx;

  // Operation decode and queue conditions.
  always_comb begin
    op_push  = (op_kind_r == KIND_PUSH_FRONT) || (op_kind_r == KIND_PUSH_BACK);
    op_pop   = (op_kind_r == KIND_POP_FRONT) || (op_kind_r == KIND_POP_BACK);
    is_empty = (occ_r == '0);
    is_full  = (occ_r == CNT_BITS'(CAPACITY));
    back_idx = ring_add(front_r, occ_r - CNT_BITS'(1));
  end

  // Status to the controller.
  always_comb begin
    stat.in_kind_ok = (in_data.kind <= KIND_DUMP);
    stat.imm_case   = op_push || is_empty;
    stat.read_last  = (remain_r == CNT_BITS'(1));
    stat.out_free   = !out_valid_r || !out_stall;
  end

  // Store addressing and enables.
  always_comb begin
    mem_we  = cmd.exec_imm && op_push && !is_full;
    wr_addr = (op_kind_r == KIND_PUSH_FRONT) ? ring_dec(front_r) : ring_add(front_r, occ_r);
    mem_re  = cmd.start_read || (cmd.emit_read && (remain_r != CNT_BITS'(1)));
    if (cmd.emit_read) begin
      rd_addr = dptr_r;
    end else if (op_kind_r == KIND_POP_BACK) begin
      rd_addr = back_idx;
    end else begin
      rd_addr = front_r;
    end
  end

  // Queue pointer and dump walker updates.
  always_comb begin
    front_nxt  = front_r;
    occ_nxt    = occ_r;
    dptr_nxt   = dptr_r;
    remain_nxt = remain_r;
    if (mem_we) begin
      occ_nxt = occ_r + CNT_BITS'(1);
      if (op_kind_r == KIND_PUSH_FRONT) begin
        front_nxt = ring_dec(front_r);
      end
    end
    if (cmd.start_read) begin
      if (op_pop) begin
        occ_nxt    = occ_r - CNT_BITS'(1);
        remain_nxt = CNT_BITS'(1);
        if (op_kind_r == KIND_POP_FRONT) begin
          front_nxt = ring_inc(front_r);
        end
      end else begin
        remain_nxt = occ_r;
        dptr_nxt   = ring_inc(front_r);
      end
    end
    if (cmd.emit_read && (remain_r != CNT_BITS'(1))) begin
      remain_nxt = remain_r - CNT_BITS'(1);
      dptr_nxt   = ring_inc(dptr_r);
    end
  end

  // Output register load.
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.exec_imm) begin
      out_nxt.word_out    = '0;
      out_nxt.status      = op_push ? (is_full ? ST_FULL : ST_OK) : ST_EMPTY;
      out_nxt.last_of_run = 1'b1;
      out_valid_nxt       = 1'b1;
    end else if (cmd.emit_read) begin
      out_nxt.word_out    = 32'(rd_data_r);
      out_nxt.status      = ST_OK;
      out_nxt.last_of_run = (remain_r == CNT_BITS'(1));
      out_valid_nxt       = 1'b1;
    end
  end

  // Ring store with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= op_word_r;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_kind_r <= in_data.kind;
      op_word_r <= WORD_BITS'(in_data.word_in);
    end
    dptr_r   <= dptr_nxt;
    remain_r <= remain_nxt;
    out_r    <= out_nxt;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/deq_ctrl.sv */
// Controller state machine of the deque: sequences accept, execute and read-out steps.
module deq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  deq_pkg::dp_stat_t stat,
  output deq_pkg::dp_cmd_t  cmd
);
  import deq_pkg::*;

  state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && stat.in_kind_ok) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stat.imm_case) begin
          state_nxt = S_READ;
        end else if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        if (stat.out_free && stat.read_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        cmd.exec_imm   = stat.imm_case && stat.out_free;
        cmd.start_read = !stat.imm_case;
      end
      S_READ: begin
        cmd.emit_read = stat.out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/double_ended_queue_top.sv */
// Top level of the bounded double-ended queue: controller plus datapath.
//
//   Channel  Direction  Handshake               Word
//   in       input      in_valid / in_stall     kind, word_in
//   out      output     out_valid / out_stall   word_out, status, last_of_run
//
// A push or an error case steps through accept and execute, a pop through accept,
// execute and a read step, and a dump through accept, execute and a read step per
// word; an undefined kind is dropped at acceptance. The result of a push or an error
// case is loaded by the execute step, each read word by its read step. One operation
// is in progress at a time. Reset is synchronous and active low; it empties the queue
// and drops the output word. A stalled valid output word holds back the next result load.
module double_ended_queue_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  deq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output deq_pkg::out_t out_data
);
  import deq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store and output register.
  deq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* tb/double_ended_queue_top_tb.sv */
// Self-checking testbench for the double-ended queue: directed, fill and random traffic.
module double_ended_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int unsigned DEPTH = CAPACITY;
  // Longest dump plus pipeline slack, used when letting the block settle.
  localparam int SETTLE_CYCLES = CAPACITY + 16;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;

  // When low, neither side inserts gaps or stalls.
  bit idle_on = 1'b1;
  int fail_count = 0;

  // Mirror of the queue contents and the results still owed by the block.
  word_t       mirror_store [DEPTH];
  int unsigned mirror_front = 0;
  int unsigned mirror_count = 0;
  out_t        owed_results [$];

  double_ended_queue_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // Apply one accepted operation to the mirror and queue the results it owes.
  task automatic apply_deque_op(input in_t op);
    out_t        res;
    int unsigned i;
    res = '0;
    res.last_of_run = 1'b1;
    case (op.kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (mirror_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (op.kind == KIND_PUSH_FRONT) begin
            mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
            mirror_store[mirror_front] = word_t'(op.word_in);
          end else begin
            mirror_store[(mirror_front + mirror_count) % DEPTH] = word_t'(op.word_in);
          end
          mirror_count++;
          res.status = ST_OK;
        end
        owed_results.push_back(res);
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (mirror_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (op.kind == KIND_POP_FRONT) begin
            res.word_out = mirror_store[mirror_front];
            mirror_front = (mirror_front + 1) % DEPTH;
          end else begin
            res.word_out = mirror_store[(mirror_front + mirror_count - 1) % DEPTH];
          end
          mirror_count--;
          res.status = ST_OK;
        end
        owed_results.push_back(res);
      end
      KIND_DUMP: begin
        if (mirror_count == 0) begin
          res.status = ST_EMPTY;
          owed_results.push_back(res);
        end else begin
          for (i = 0; i < mirror_count; i++) begin
            res.word_out    = mirror_store[(mirror_front + i) % DEPTH];
            res.status      = ST_OK;
            res.last_of_run = (i + 1 == mirror_count);
            owed_results.push_back(res);
          end
        end
      end
      default: begin
        // Undefined kinds are dropped by the block without a result.
      end
    endcase
  endtask

  // Send one operation word, after a random gap, and wait until it is taken.
  task automatic send_op(input logic [2:0] op_kind, input logic signed [31:0] value);
    in_t item;
    int  gap;
    item.kind    = op_kind;
    item.word_in = value;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    apply_deque_op(item);
  endtask

  // Hold off the sender until every owed result has arrived, then let it settle.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Data word with the sign, zero and all-ones patterns drawn more often.
  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Operation mix: a few undefined kinds, some dumps, pushes at the given share.
  function automatic logic [2:0] pick_kind(input int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 3'($urandom_range(5, 7));
    if (r < 11) return KIND_DUMP;
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
    end
    return $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
  endfunction

  // Pops and dumps on an empty queue, and the undefined kinds.
  task automatic test_empty_queue();
    send_op(KIND_POP_FRONT, rand_word());
    send_op(KIND_POP_BACK, rand_word());
    send_op(KIND_DUMP, rand_word());
    send_op(3'd5, WORD_MAX);
    send_op(3'd6, WORD_MIN);
    send_op(3'd7, -32'sd1);
    send_op(KIND_POP_FRONT, '0);
    wait_for_drain();
  endtask

  // Extreme data words pushed at both ends, read back by pops and dumps.
  task automatic test_extreme_words();
    send_op(KIND_PUSH_BACK, WORD_MIN);
    send_op(KIND_PUSH_BACK, WORD_MAX);
    send_op(KIND_PUSH_FRONT, '0);
    send_op(KIND_PUSH_FRONT, -32'sd1);
    send_op(KIND_PUSH_FRONT, 32'sh5555_5555);
    send_op(KIND_PUSH_BACK, 32'shAAAA_AAAA);
    send_op(KIND_DUMP, '0);
    send_op(KIND_POP_FRONT, -32'sd1);
    send_op(KIND_POP_BACK, WORD_MIN);
    send_op(KIND_POP_BACK, '0);
    send_op(KIND_POP_FRONT, WORD_MAX);
    send_op(KIND_DUMP, -32'sd1);
    send_op(KIND_POP_FRONT, '0);
    send_op(KIND_POP_BACK, '0);
    send_op(KIND_POP_BACK, '0);
    wait_for_drain();
  endtask

  // Fill to capacity from random ends, push into a full queue, dump, empty it, then pop once more.
  task automatic test_fill_and_overflow();
    int n;
    while (mirror_count < DEPTH) begin
      send_op($urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, rand_word());
    end
    send_op(KIND_PUSH_FRONT, rand_word());
    send_op(KIND_PUSH_BACK, rand_word());
    send_op(KIND_DUMP, rand_word());
    send_op(KIND_PUSH_BACK, rand_word());
    for (n = 0; mirror_count > 0; n++) begin
      send_op(n[0] ? KIND_POP_BACK : KIND_POP_FRONT, rand_word());
    end
    send_op(KIND_POP_BACK, rand_word());
    wait_for_drain();
  endtask

  // Random traffic in phases that lean toward growing, shrinking or neither.
  task automatic test_random_traffic();
    int push_share [4] = '{75, 25, 50, 60};
    bit idle_phase [4] = '{1'b1, 1'b1, 1'b0, 1'b1};
    int p;
    int n;
    for (p = 0; p < 4; p++) begin
      idle_on = idle_phase[p];
      for (n = 0; n < 60; n++) begin
        send_op(pick_kind(push_share[p]), rand_word());
      end
      wait_for_drain();
    end
    idle_on = 1'b1;
  endtask

  // Result side: a random stall before each result word, none when idling is off.
  initial begin : result_stall
    int gap;
    forever begin
      gap = idle_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Compare every accepted result word with the oldest owed result.
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (owed_results.size() == 0) begin
        $error("unexpected result word: word_out %0d status %0d last_of_run %0b",
               out_data.word_out, out_data.status, out_data.last_of_run);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        if (out_data.word_out !== want.word_out) begin
          $error("word_out expected %0d actual %0d", want.word_out, out_data.word_out);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $error("last_of_run expected %0b actual %0b", want.last_of_run,
                 out_data.last_of_run);
          fail_count++;
        end
      end
    end
  end

  // Test sequence.
  initial begin : run_tests
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queue();
    test_extreme_words();
    test_fill_and_overflow();
    test_random_traffic();
    // Let any stray result word show up with the result side never stalling.
    idle_on = 1'b0;
    wait_for_drain();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin : watchdog
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
rtl/deq_pkg.sv
rtl/deq_dp.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue_top.sv
tb/double_ended_queue_top_tb.sv
